>>> hw/rtl/mdi_pkg.sv
package mdi_pkg;

  localparam int MaxRows  = 16;
  localparam int MaxOrder = 3;
  localparam int AAddrW   = $clog2(MaxRows * MaxOrder);
  localparam int BAddrW   = $clog2(MaxOrder * MaxOrder);

  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISMATCH = 3'd1;
  localparam logic [2:0] ST_NOT_SQ   = 3'd2;
  localparam logic [2:0] ST_TOO_BIG  = 3'd3;
  localparam logic [2:0] ST_SINGULAR = 3'd4;
  localparam logic [2:0] ST_SAT      = 3'd5;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_COF_RD, S_COF_MUL, S_COF_END, S_DET, S_DET_END,
    S_ROW_MUL, S_DIV, S_OUT
  } state_t;

endpackage

>>> hw/rtl/mdi_stream_if.sv
interface mdi_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hw/rtl/matrix_divide_by_inverse.sv
// Computes A * inverse(B) in Q16.16. Loads of A (up to 16x3) and B (up to 3x3)
// are taken one per cycle. A start request checks the sizes and builds the
// adjugate and determinant of B; their products use one shared 32x32
// multiplier. Then, for every result element, it forms the dot product on
// that multiplier (per term: fetch A, then multiply) and divides by the
// determinant with a radix-2 restoring divider. The input is not ready while
// a start request is in work; loads are still taken while a finished result
// waits. Errors give one result with a status code and last set.
module matrix_divide_by_inverse
  import mdi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mdi_stream_if.sink   in_req,
  mdi_stream_if.source out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  // in_req.data = {func[39:38], row_index[37:34], col_index[33:32], element_value[31:0]}
  // out_res.data = {result_value[41:10], result_row[9:6], result_col[5:4], status[3:1], last[0]}

  logic [4:0] a_rows, a_cols, b_rows, b_cols;
  logic [31:0] a_mem [MaxRows*MaxOrder];
  logic [31:0] b_reg [MaxOrder*MaxOrder];
  logic signed [31:0] adj [MaxOrder*MaxOrder];
  logic signed [31:0] det;
  logic isat;
  logic started;

  state_t state, state_next;

  logic [1:0] func;
  logic [3:0] in_row;
  logic [1:0] in_col;
  logic [31:0] in_val;
  assign func   = in_req.data[39:38];
  assign in_row = in_req.data[37:34];
  assign in_col = in_req.data[33:32];
  assign in_val = in_req.data[31:0];

  logic acc_in;
  assign in_req.ready = (state == S_IDLE);
  assign acc_in = in_req.valid && in_req.ready;

  // config
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= 5'd1; a_cols <= 5'd1; b_rows <= 5'd1; b_cols <= 5'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_A_ROWS: a_rows <= pwdata[4:0];
        REG_A_COLS: a_cols <= pwdata[4:0];
        REG_B_ROWS: b_rows <= pwdata[4:0];
        REG_B_COLS: b_cols <= pwdata[4:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      REG_A_ROWS: prdata = {27'd0, a_rows};
      REG_A_COLS: prdata = {27'd0, a_cols};
      REG_B_ROWS: prdata = {27'd0, b_rows};
      default:    prdata = {27'd0, b_cols};
    endcase
  end

  // loads
  always_ff @(posedge clk) begin
    if (acc_in && func == FUNC_LOAD_A && in_col < 2'(MaxOrder))
      a_mem[AAddrW'(in_row) * AAddrW'(MaxOrder) + AAddrW'(in_col)] <= in_val;
  end

  // sequencer counters
  logic [1:0] ci, cj, ck;      // cofactor row/col, term index
  logic [3:0] ri;              // result row
  logic [1:0] n;
  logic [4:0] rows;
  logic signed [63:0] acc;
  logic        rsat;
  logic [31:0] a_rd;

  // shared multiplier
  logic signed [31:0] mx, my;
  logic signed [63:0] prod;
  assign prod = mx * my;

  function automatic logic [BAddrW-1:0] bidx(input logic [1:0] r, input logic [1:0] c);
    return BAddrW'(r) * BAddrW'(MaxOrder) + BAddrW'(c);
  endfunction

  // cofactor minor element selection: term 0 = b(r0,c0)*b(r1,c1), 1 = b(r1,c0)*b(r0,c1)
  logic [1:0] r0, r1, c0, c1;
  assign r0 = (ci == 2'd0) ? 2'd1 : 2'd0;
  assign r1 = (ci == 2'd2) ? 2'd1 : 2'd2;
  assign c0 = (cj == 2'd0) ? 2'd1 : 2'd0;
  assign c1 = (cj == 2'd2) ? 2'd1 : 2'd2;

  always_comb begin
    mx = '0; my = '0;
    unique case (state)
      S_COF_MUL: begin
        if (n == 2'd2) begin
          mx = ck[0] ? b_reg[bidx(2'd1, 2'd0)] : b_reg[bidx(2'd0, 2'd0)];
          my = ck[0] ? b_reg[bidx(2'd0, 2'd1)] : b_reg[bidx(2'd1, 2'd1)];
        end else begin
          mx = ck[0] ? b_reg[bidx(r1, c0)] : b_reg[bidx(r0, c0)];
          my = ck[0] ? b_reg[bidx(r0, c1)] : b_reg[bidx(r1, c1)];
        end
      end
      S_DET: begin
        mx = b_reg[bidx(2'd0, ck)];
        my = adj[bidx(ck, 2'd0)];
      end
      S_ROW_MUL: begin
        mx = a_rd;
        my = adj[bidx(ck, cj)];
      end
      default: ;
    endcase
  end

  // saturating helpers
  function automatic logic signed [63:0] sadd(input logic signed [63:0] x,
                                              input logic signed [63:0] y,
                                              output logic s);
    logic signed [63:0] t;
    t = x + y;
    s = (x[63] == y[63]) && (t[63] != x[63]);
    if (s) return x[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return t;
  endfunction

  function automatic logic signed [31:0] rnd16(input logic signed [63:0] x,
                                               output logic s);
    logic signed [48:0] q;
    q = 49'(x >>> 16) + 49'(x[15]);
    s = (q > 49'sd2147483647) || (q < -49'sd2147483648);
    if (s) return q[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return q[31:0];
  endfunction

  logic add_s;
  logic signed [63:0] add_r;
  // acc + prod, saturating
  always_comb begin
    add_r = sadd(acc, prod, add_s);
  end

  // divider: |acc| / |det|, 64 steps
  logic [63:0] dq;
  logic [64:0] drem;
  logic [31:0] dden;
  logic [6:0]  dcnt;
  logic        dneg;
  logic [64:0] trial;
  assign trial = {drem[63:0], dq[63]} - {33'd0, dden};

  logic [31:0] rv;
  logic        rv_s;
  always_comb begin
    logic [64:0] q1;
    q1 = {1'b0, dq} + 65'(drem >= 65'({33'd0, dden}) - drem);
    rv_s = 1'b0;
    if (!dneg) begin
      if (q1 > 65'd2147483647) begin rv_s = 1'b1; rv = 32'h7FFF_FFFF; end
      else rv = q1[31:0];
    end else begin
      if (q1 > 65'd2147483648) begin rv_s = 1'b1; rv = 32'h8000_0000; end
      else rv = 32'(-q1[31:0]);
    end
  end

  // output register
  logic [31:0] o_val;
  logic [3:0]  o_row;
  logic [1:0]  o_col;
  logic [2:0]  o_st;
  logic        o_last;
  assign out_res.data = {o_val, o_row, o_col, o_st, o_last};

  logic err_go;
  logic [2:0] err_st;
  always_comb begin
    err_go = 1'b1; err_st = ST_OK;
    priority if (a_cols != b_rows || a_rows == 5'd0 || a_rows > 5'(MaxRows)) err_st = ST_MISMATCH;
    else if (b_rows != b_cols) err_st = ST_NOT_SQ;
    else if (b_rows == 5'd0 || b_rows > 5'(MaxOrder)) err_st = ST_TOO_BIG;
    else err_go = 1'b0;
  end

  logic singular, res_last;
  assign singular = !started && det == 32'sd0;
  assign res_last = (5'(ri) + 5'd1 == rows) && (cj + 2'd1 == n);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (acc_in && func == FUNC_START) state_next = S_CHECK;
      S_CHECK: begin
        if (err_go) begin
          if (!out_res.valid) state_next = S_IDLE;
        end else if (b_rows == 5'd1) state_next = S_DET_END;
        else state_next = S_COF_MUL;
      end
      S_COF_MUL: if (ck[0]) state_next = S_COF_END;
      S_COF_END: begin
        if (n == 2'd2) state_next = S_DET_END;
        else if (ci == 2'd2 && cj == 2'd2) state_next = S_DET;
        else state_next = S_COF_MUL;
      end
      S_DET:     if (ck == 2'd2) state_next = S_DET_END;
      S_DET_END: state_next = S_COF_RD;
      S_COF_RD: begin
        // singular check once, then fetch A element
        if (singular) begin
          if (!out_res.valid) state_next = S_IDLE;
        end else state_next = S_ROW_MUL;
      end
      S_ROW_MUL: state_next = (ck + 2'd1 == n) ? S_DIV : S_COF_RD;
      S_DIV:     if (dcnt == 7'd63) state_next = S_OUT;
      S_OUT: begin
        if (!out_res.valid) state_next = res_last ? S_IDLE : S_COF_RD;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    logic s1;
    logic signed [31:0] d;
    if (rst) begin
      state <= S_IDLE;
      out_res.valid <= 1'b0;
      started <= 1'b0;
    end else begin
      state <= state_next;
      if (out_res.valid && out_res.ready) out_res.valid <= 1'b0;
      if (acc_in && func == FUNC_LOAD_B && in_row < 4'(MaxOrder) && in_col < 2'(MaxOrder))
        b_reg[bidx(in_row[1:0], in_col)] <= in_val;
      unique case (state)
        S_IDLE: begin
          isat <= 1'b0; acc <= '0; ci <= '0; cj <= '0; ck <= '0; started <= 1'b0;
        end
        S_CHECK: begin
          n <= b_rows[1:0]; rows <= a_rows;
          if (err_go) begin
            // hold the error until the previous result has left
            if (!out_res.valid) begin
              out_res.valid <= 1'b1;
              {o_val, o_row, o_col, o_st, o_last} <= {32'd0, 4'd0, 2'd0, err_st, 1'b1};
            end
          end else if (b_rows == 5'd1) begin
            adj[bidx(2'd0, 2'd0)] <= 32'sd65536;
            det <= b_reg[bidx(2'd0, 2'd0)];
          end else if (b_rows == 5'd2) begin
            adj[bidx(2'd0, 2'd0)] <= b_reg[bidx(2'd1, 2'd1)];
            adj[bidx(2'd1, 2'd1)] <= b_reg[bidx(2'd0, 2'd0)];
            adj[bidx(2'd0, 2'd1)] <= (b_reg[bidx(2'd0, 2'd1)] == 32'sh8000_0000) ?
                                     32'sh7FFF_FFFF : -b_reg[bidx(2'd0, 2'd1)];
            adj[bidx(2'd1, 2'd0)] <= (b_reg[bidx(2'd1, 2'd0)] == 32'sh8000_0000) ?
                                     32'sh7FFF_FFFF : -b_reg[bidx(2'd1, 2'd0)];
            isat <= (b_reg[bidx(2'd0, 2'd1)] == 32'sh8000_0000) ||
                    (b_reg[bidx(2'd1, 2'd0)] == 32'sh8000_0000);
          end
        end
        S_COF_MUL: begin
          acc <= ck[0] ? acc - prod : prod;
          ck <= ck[0] ? 2'd0 : 2'd1;
        end
        S_COF_END: begin
          d = rnd16((ci[0] ^ cj[0]) ? -acc : acc, s1);
          if (n == 2'd2) begin
            det <= rnd16(acc, s1);
            isat <= isat | s1;
          end else begin
            adj[bidx(cj, ci)] <= d;
            isat <= isat | s1;
            acc <= '0;
            if (ci == 2'd2 && cj == 2'd2) begin
              ck <= '0;
            end else begin
              if (cj == 2'd2) begin cj <= '0; ci <= ci + 2'd1; end
              else cj <= cj + 2'd1;
            end
          end
        end
        S_DET: begin
          acc <= add_r;
          isat <= isat | add_s;
          ck <= ck + 2'd1;
        end
        S_DET_END: begin
          if (n == 2'd3) begin
            det <= rnd16(acc, s1);
            isat <= isat | s1;
          end
          ri <= '0; cj <= '0; ck <= '0;
        end
        S_COF_RD: begin
          if (singular) begin
            if (!out_res.valid) begin
              out_res.valid <= 1'b1;
              {o_val, o_row, o_col, o_st, o_last} <= {32'd0, 4'd0, 2'd0, ST_SINGULAR, 1'b1};
            end
          end else begin
            started <= 1'b1;
            a_rd <= a_mem[AAddrW'(ri) * AAddrW'(MaxOrder) + AAddrW'(ck)];
            if (ck == 2'd0) begin acc <= '0; rsat <= isat; end
          end
        end
        S_ROW_MUL: begin
          acc <= add_r;
          rsat <= rsat | add_s;
          if (ck + 2'd1 == n) begin
            dneg <= add_r[63] ^ det[31];
            dq <= add_r[63] ? 64'(-add_r) : 64'(add_r);
            drem <= '0;
            dden <= det[31] ? 32'(-det) : 32'(det);
            dcnt <= '0;
          end else begin
            ck <= ck + 2'd1;
          end
        end
        S_DIV: begin
          if (trial[64]) begin
            drem <= {drem[63:0], dq[63]};
            dq <= {dq[62:0], 1'b0};
          end else begin
            drem <= trial;
            dq <= {dq[62:0], 1'b1};
          end
          dcnt <= dcnt + 7'd1;
        end
        S_OUT: begin
          if (!out_res.valid) begin
            out_res.valid <= 1'b1;
            o_val <= rv; o_row <= ri; o_col <= cj;
            o_st <= (rsat | rv_s) ? ST_SAT : ST_OK;
            o_last <= res_last;
            ck <= '0;
            if (!res_last) begin
              if (cj + 2'd1 == n) begin cj <= '0; ri <= ri + 4'd1; end
              else cj <= cj + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

>>> tb/mdi_test_if.sv
`timescale 1ns / 1ps
// Payload layouts assumed for the two streams, most significant field first.
package mdi_test_types;
  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  row;
    logic [1:0]  col;
    logic [2:0]  status;
    logic        last;
  } res_t;
endpackage

>>> tb/matrix_divide_by_inverse_test.sv
`timescale 1ns / 1ps
module matrix_divide_by_inverse_test;
  import mdi_pkg::*;
  import mdi_test_types::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int hold_cycles = 0;

  mdi_stream_if #(.W(40)) req_ch ();
  mdi_stream_if #(.W(42)) res_ch ();

  matrix_divide_by_inverse uut (
    .clk(clk), .rst(rst), .in_req(req_ch.sink), .out_res(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  class quotient_board;
    logic signed [31:0] a_mem [MaxRows*MaxOrder];
    logic signed [31:0] b_mem [MaxOrder*MaxOrder];
    int unsigned a_rows = 1, a_cols = 1, b_rows = 1, b_cols = 1;
    res_t pending_q [$];
    int errors = 0;

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    function void set_reg(int idx, int unsigned v);
      v = v & 5'h1f;
      case (idx)
        REG_A_ROWS: a_rows = v;
        REG_A_COLS: a_cols = v;
        REG_B_ROWS: b_rows = v;
        REG_B_COLS: b_cols = v;
        default: ;
      endcase
    endfunction

    function longint sat32(longint v, inout bit s);
      if (v > 64'sd2147483647) begin
        s = 1; return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        s = 1; return -64'sd2147483648;
      end
      return v;
    endfunction

    // round half up from Q32 to Q16
    function longint round16(longint x, inout bit s);
      longint q;
      q = x >>> 16;
      if (x[15]) q++;
      return sat32(q, s);
    endfunction

    function longint sadd(longint a, longint b, inout bit s);
      longint r;
      r = a + b;
      if (b > 0 && r < a) begin
        s = 1; return 64'h7fffffffffffffff;
      end
      if (b < 0 && r > a) begin
        s = 1; return 64'h8000000000000000;
      end
      return r;
    endfunction

    function longint rdiv(longint sv, longint d, inout bit s);
      longint unsigned ns, nd, q, rm;
      bit neg;
      ns = sv < 0 ? -sv : sv;
      nd = d < 0 ? -d : d;
      q = ns / nd;
      rm = ns % nd;
      neg = (sv < 0) != (d < 0);
      if (rm >= nd - rm) q++;
      if (!neg) begin
        if (q > 64'd2147483647) begin
          s = 1; return 64'sd2147483647;
        end
        return longint'(q);
      end
      if (q > 64'd2147483648) begin
        s = 1; return -64'sd2147483648;
      end
      return -longint'(q);
    endfunction

    function longint bv(int r, int c);
      return longint'(b_mem[r*MaxOrder+c]);
    endfunction

    function void push_err(logic [2:0] st);
      res_t e;
      e = '0;
      e.status = st;
      e.last = 1'b1;
      pending_q.push_back(e);
    endfunction

    function void note(req_t r);
      longint adj [3][3];
      longint det, acc, m, sv, v;
      bit isat, rsat;
      int n, r0, r1, c0, c1;
      res_t e;
      if (r.func == FUNC_LOAD_A) begin
        if (r.col < MaxOrder) a_mem[r.row*MaxOrder+r.col] = r.value;
        return;
      end
      if (r.func == FUNC_LOAD_B) begin
        if (r.row < MaxOrder && r.col < MaxOrder) b_mem[r.row*MaxOrder+r.col] = r.value;
        return;
      end
      if (r.func != FUNC_START) return;
      if (a_cols != b_rows || a_rows == 0 || a_rows > MaxRows) begin
        push_err(ST_MISMATCH); return;
      end
      if (b_rows != b_cols) begin
        push_err(ST_NOT_SQ); return;
      end
      if (b_rows == 0 || b_rows > MaxOrder) begin
        push_err(ST_TOO_BIG); return;
      end
      n = b_rows;
      isat = 0;
      if (n == 1) begin
        adj[0][0] = 65536;
        det = bv(0, 0);
      end else if (n == 2) begin
        adj[0][0] = bv(1, 1);
        adj[1][1] = bv(0, 0);
        adj[0][1] = sat32(-bv(0, 1), isat);
        adj[1][0] = sat32(-bv(1, 0), isat);
        det = round16(bv(0, 0)*bv(1, 1) - bv(1, 0)*bv(0, 1), isat);
      end else begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) begin
            r0 = i == 0 ? 1 : 0; r1 = i == 2 ? 1 : 2;
            c0 = j == 0 ? 1 : 0; c1 = j == 2 ? 1 : 2;
            m = bv(r0, c0)*bv(r1, c1) - bv(r1, c0)*bv(r0, c1);
            if ((i + j) % 2) m = -m;
            adj[j][i] = round16(m, isat);
          end
        acc = 0;
        for (int j = 0; j < 3; j++) acc = sadd(acc, bv(0, j)*adj[j][0], isat);
        det = round16(acc, isat);
      end
      if (det == 0) begin
        push_err(ST_SINGULAR); return;
      end
      for (int i = 0; i < a_rows; i++)
        for (int j = 0; j < n; j++) begin
          rsat = isat;
          sv = 0;
          for (int z = 0; z < n; z++)
            sv = sadd(sv, longint'(a_mem[i*MaxOrder+z])*adj[z][j], rsat);
          v = rdiv(sv, det, rsat);
          e.value = v[31:0];
          e.row = 4'(i);
          e.col = 2'(j);
          e.status = rsat ? ST_SAT : ST_OK;
          e.last = (i + 1 == a_rows && j + 1 == n);
          pending_q.push_back(e);
        end
    endfunction

    task check(res_t got);
      res_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result %h", got)); return;
      end
      e = pending_q.pop_front();
      if (got.value !== e.value)
        report($sformatf("value %h, want %h", got.value, e.value));
      if (got.row !== e.row) report($sformatf("row %0d, want %0d", got.row, e.row));
      if (got.col !== e.col) report($sformatf("col %0d, want %0d", got.col, e.col));
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
      if (got.last !== e.last) report($sformatf("last %b, want %b", got.last, e.last));
    endtask
  endclass

  quotient_board board = new();

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 19);
    if (k < 10) return 0;
    if (k < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h0;
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(0, 32'h80000) - 32'h40000;
    endcase
  endfunction

  // call at a falling edge; returns at a falling edge
  task automatic send_req(logic [1:0] f, int r, int c, int v);
    req_t q;
    int gap;
    q = '{func: f, row: 4'(r), col: 2'(c), value: 32'(v)};
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= q;
    do @(posedge clk); while (!req_ch.ready);
    board.note(q);
    @(negedge clk);
  endtask

  task automatic write_reg(int idx, int unsigned v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 4'(idx*4); pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, v);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // drain outstanding results, then let the datapath settle before reprogramming
  task automatic set_sizes(int ar, int ac, int br, int bc);
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    write_reg(REG_A_ROWS, ar);
    write_reg(REG_A_COLS, ac);
    write_reg(REG_B_ROWS, br);
    write_reg(REG_B_COLS, bc);
  endtask

  task automatic random_load();
    int k;
    k = $urandom_range(0, 19);
    if (k < 11) send_req(FUNC_LOAD_A, $urandom_range(0, 15), $urandom_range(0, 2),
                         pick_value());
    else if (k < 17) send_req(FUNC_LOAD_B, $urandom_range(0, 2), $urandom_range(0, 2),
                              pick_value());
    else if (k < 18) send_req(2'd3, $urandom(), $urandom(), $urandom());
    else send_req(2'($urandom_range(0, 1)), $urandom(), 3, $urandom());
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      res_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (!rst) begin
      res_ch.ready <= ($urandom_range(0, 29) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk)
    if (!rst && res_ch.valid && res_ch.ready) board.check(res_ch.data);

  initial begin
    int ar, n, cnt;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // fill both stores so that no start reads an unwritten entry
    for (int i = 0; i < MaxRows; i++)
      for (int j = 0; j < MaxOrder; j++)
        send_req(FUNC_LOAD_A, i, j, (i == 0 && j == 0) ? 32'h7fffffff : pick_value());
    for (int i = 0; i < MaxOrder; i++)
      for (int j = 0; j < MaxOrder; j++)
        send_req(FUNC_LOAD_B, i, j, (i == j) ? 32'h00010000 : 32'h0);
    send_req(FUNC_START, 0, 0, 0);
    // singular 1x1, then extreme B
    send_req(FUNC_LOAD_B, 0, 0, 32'h0);
    send_req(FUNC_START, 0, 0, 0);
    send_req(FUNC_LOAD_B, 0, 0, 32'h80000000);
    send_req(FUNC_LOAD_B, 1, 1, 32'h80000000);
    send_req(FUNC_LOAD_B, 0, 1, 32'h80000000);
    send_req(FUNC_START, 0, 0, 0);
    set_sizes(16, 2, 2, 2);
    send_req(FUNC_START, 0, 0, 0);
    set_sizes(16, 3, 3, 3);
    send_req(FUNC_START, 0, 0, 0);
    send_req(FUNC_LOAD_B, 0, 0, 32'h0);
    send_req(FUNC_LOAD_B, 1, 0, 32'h0);
    send_req(FUNC_LOAD_B, 2, 0, 32'h0);
    send_req(FUNC_START, 0, 0, 0);
    // error checks in priority order
    set_sizes(2, 3, 2, 2);  send_req(FUNC_START, 0, 0, 0);
    set_sizes(0, 1, 1, 1);  send_req(FUNC_START, 0, 0, 0);
    set_sizes(31, 1, 1, 1); send_req(FUNC_START, 0, 0, 0);
    set_sizes(1, 2, 2, 3);  send_req(FUNC_START, 0, 0, 0);
    set_sizes(1, 0, 0, 0);  send_req(FUNC_START, 0, 0, 0);
    set_sizes(1, 31, 31, 31); send_req(FUNC_START, 0, 0, 0);
    set_sizes(17, 4, 4, 4); send_req(FUNC_START, 0, 0, 0);

    // long receiver stall while the sender keeps offering requests
    set_sizes(16, 3, 3, 3);
    for (int i = 0; i < 3; i++) send_req(FUNC_LOAD_B, i, i, 32'h00020000);
    hold_cycles = 3000;
    send_req(FUNC_START, 0, 0, 0);
    for (int i = 0; i < 6; i++) random_load();
    send_req(FUNC_START, 0, 0, 0);

    cnt = 0;
    while (cnt < 310) begin
      n = $urandom_range(1, 3);
      ar = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 4);
      case ($urandom_range(0, 9))
        0: set_sizes(ar, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
        1: set_sizes($urandom_range(0, 31), n, n, n);
        default: set_sizes(ar, n, n, n);
      endcase
      for (int k = $urandom_range(3, 30); k > 0; k--) begin
        random_load();
        cnt++;
      end
      for (int k = $urandom_range(1, 2); k > 0; k--) begin
        send_req(FUNC_START, $urandom(), $urandom(), $urandom());
        cnt++;
      end
    end

    req_ch.valid <= 1'b0;
    while (board.pending_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
